// File: src/crtc_pkg.sv
// ----------------------------------------------------------------------------
// crtc_pkg: shared types for the clock replacement tag cache
// Request and response payloads, command codes and sequencer states.
// ----------------------------------------------------------------------------
package crtc_pkg;

   // command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // request transfer
   typedef struct packed {
      logic        cmd;
      logic [31:0] key;
   } req_type;

   // response transfer
   typedef struct packed {
      logic       hit;
      logic [3:0] slot;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT
   } state_type;

endpackage

// File: src/crtc_tag_ram.sv
// ----------------------------------------------------------------------------
// crtc_tag_ram: tag storage
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module crtc_tag_ram #(
   parameter int DEPTH = 10,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/crtc_seq.sv
// ----------------------------------------------------------------------------
// crtc_seq: lookup / insert sequencer
// Scans slots one per cycle through a single tag comparator, walks the
// clock hand over use bits, keeps valid/use bits and the response register.
// ----------------------------------------------------------------------------
module crtc_seq #(
   parameter int ENTRIES   = 10,
   parameter int KEY_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  crtc_pkg::req_type          req,
   output logic                       rsp_strobe,
   output crtc_pkg::rsp_type          rsp,
   output logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  logic [KEY_WIDTH-1:0]       rd_data,
   output logic                       wr_en,
   output logic [$clog2(ENTRIES)-1:0] wr_addr,
   output logic [KEY_WIDTH-1:0]       wr_data
);
   import crtc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     hand_ff, hand_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [ENTRIES-1:0]   used_ff, used_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 match;
   logic                 last;
   logic                 hand_used;
   logic                 scan_done;
   logic                 ins_done;
   logic [IDX_W-1:0]     idx_next;
   logic [IDX_W-1:0]     hand_next;
   logic [KEY_WIDTH+31:0] key_ext;
   logic [IDX_W+3:0]     idx_ext;
   logic [IDX_W+3:0]     hand_ext;

   // key fitted to the stored tag width
   assign key_ext = {{KEY_WIDTH{1'b0}}, req.key};
   assign key_in  = key_ext[KEY_WIDTH-1:0];

   // slot indexes fitted to the 4-bit response field
   assign idx_ext  = {4'b0000, idx_ff};
   assign hand_ext = {4'b0000, hand_ff};

   // compare and increment logic
   assign accept    = start && (state_ff == ST_IDLE);
   assign match     = valid_ff[idx_ff] && (rd_data == key_ff);
   assign last      = (idx_ff == LAST_IDX);
   assign hand_used = used_ff[hand_ff];
   assign idx_next  = last ? '0 : idx_ff + 1'b1;
   assign hand_next = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req.cmd == CMD_INSERT) ? ST_INSERT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || last) begin
               state_in = ST_IDLE;
            end
         end
         ST_INSERT: begin
            if (!hand_used) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      rd_addr   = '0;
      scan_done = 1'b0;
      ins_done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
         end
         ST_SCAN: begin
            rd_addr   = idx_next;
            scan_done = match || last;
         end
         ST_INSERT: begin
            ins_done = !hand_used;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
      wr_en   = ins_done;
      wr_addr = hand_ff;
      wr_data = key_ff;
   end

   // slot bits, hand and index updates
   always_comb begin
      idx_in   = idx_ff;
      hand_in  = hand_ff;
      valid_in = valid_ff;
      used_in  = used_ff;
      if (state_ff == ST_IDLE) begin
         idx_in = '0;
      end
      if (state_ff == ST_SCAN) begin
         idx_in = idx_next;
         if (match) begin
            used_in[idx_ff] = 1'b1;
         end
      end
      if (state_ff == ST_INSERT) begin
         if (hand_used) begin
            used_in[hand_ff] = 1'b0;
            hand_in          = hand_next;
         end else begin
            used_in[hand_ff]  = 1'b1;
            valid_in[hand_ff] = 1'b1;
         end
      end
   end

   // response
   always_comb begin
      rsp_strobe_in = scan_done || ins_done;
      rsp_in        = rsp_ff;
      if (scan_done) begin
         rsp_in.hit  = match;
         rsp_in.slot = match ? idx_ext[3:0] : 4'd0;
      end else if (ins_done) begin
         rsp_in.hit  = 1'b0;
         rsp_in.slot = hand_ext[3:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         hand_ff       <= '0;
         valid_ff      <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         hand_ff       <= hand_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= key_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // a response only follows a cycle of work
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff != ST_IDLE))
      else $error("response strobe without a preceding operation");

   // hand never leaves the slot range
   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= LAST_IDX)
      else $error("clock hand out of range");

   // scan index never leaves the slot range
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("scan index out of range");

   // committed insert leaves its slot valid and used, hand parked there
   a_insert_commit: assert property (@(posedge clock) disable iff (reset)
      ins_done |=> valid_ff[hand_ff] && used_ff[hand_ff]
                   && (hand_ff == $past(hand_ff)) && rsp_strobe_ff && !rsp_ff.hit)
      else $error("insert commit did not mark its slot");

endmodule

// File: src/clock_replacement_tag_cache.sv
// ----------------------------------------------------------------------------
// clock_replacement_tag_cache: fully associative tag directory, clock policy
// Lookup: slots compared one per cycle, lowest valid match hits.
// Insert: hand skips use-bit-set slots, clearing them, then fills a slot.
// ----------------------------------------------------------------------------
// Lookup: strobe follows the compare of the hit slot k, or of the last slot
//   on a miss; one tag comparator walks the slots.
// Insert: strobe follows the sweep past n set use bits (n <= ENTRIES).
// busy drops as the strobe rises; next start taken at its end, one at a time.
// Responses cannot be stalled. Sync reset clears valid and use bits and the
//   hand at once; stored tags are not cleared (guarded by the valid bits).
// ----------------------------------------------------------------------------
module clock_replacement_tag_cache #(
   parameter int ENTRIES   = 10,
   parameter int KEY_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  crtc_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output crtc_pkg::rsp_type rsp_payload
);
   import crtc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic [IDX_W-1:0]     rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   // tag storage
   crtc_tag_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (KEY_WIDTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer and replacement state
   crtc_seq #(
      .ENTRIES   (ENTRIES),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for clock_replacement_tag_cache
// Drives lookup and insert commands through the start/busy handshake with
// random gaps. A scoreboard keeps its own copy of the tag directory, valid and
// use bits and clock hand, predicts every response and compares each strobed
// response field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crtc_pkg::*;

   localparam int ENTRIES      = 10;
   localparam int KEY_WIDTH    = 32;
   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_LIMIT   = 2000;

   // --------------------------------------------------------------------------
   // Scoreboard: directory shadow, response predictor and checker
   // --------------------------------------------------------------------------
   class tag_directory_scoreboard;
      logic [KEY_WIDTH-1:0] tags [ENTRIES];
      bit                   valid [ENTRIES];
      bit                   used [ENTRIES];
      int unsigned          hand;
      rsp_type              expected_rsps [$];
      int unsigned          failures, lookups, hits, inserts, full_turns, checked;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            valid[i] = 1'b0;
            used[i]  = 1'b0;
         end
         hand = 0;
      endfunction

      // predict the response of one accepted request and update the shadow
      function void note_request(req_type item);
         rsp_type              rsp;
         logic [KEY_WIDTH-1:0] key;
         int unsigned          passed;
         key      = item.key[KEY_WIDTH-1:0];
         rsp.hit  = 1'b0;
         rsp.slot = '0;
         if (item.cmd == CMD_LOOKUP) begin
            lookups++;
            // lowest valid match wins
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid[i] && tags[i] == key) begin
                  used[i]  = 1'b1;
                  rsp.hit  = 1'b1;
                  rsp.slot = 4'(i);
                  hits++;
                  break;
               end
            end
         end else begin
            inserts++;
            if (hand >= ENTRIES) hand = 0;
            // second chance sweep, at most one full turn
            passed = 0;
            while (passed < ENTRIES && used[hand]) begin
               used[hand] = 1'b0;
               hand = (hand + 1) % ENTRIES;
               passed++;
            end
            if (passed == ENTRIES) full_turns++;
            tags[hand]  = key;
            valid[hand] = 1'b1;
            used[hand]  = 1'b1;
            rsp.slot    = 4'(hand);
         end
         expected_rsps.push_back(rsp);
      endfunction

      // compare one strobed response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: hit=%0d slot=%0d", got.hit, got.slot);
            failures++;
            return;
         end
         want = expected_rsps.pop_front();
         checked++;
         if (got.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, got.hit);
            failures++;
         end
         if (got.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
            failures++;
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // DUT and clock
   // --------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   clock_replacement_tag_cache #(
      .ENTRIES  (ENTRIES),
      .KEY_WIDTH(KEY_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   tag_directory_scoreboard sb = new();

   logic [31:0] recent_keys [$];
   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned idle_cycles;

   // --------------------------------------------------------------------------
   // Request driver
   // --------------------------------------------------------------------------
   // gap before the next request: mostly none or short, a few long,
   // with occasional bursts of back-to-back transfers
   function automatic int unsigned gap_len();
      int unsigned pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (pick < 45) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic drive_item(input logic cmd, input logic [31:0] key);
      req_type     item;
      int unsigned gap;
      item.cmd = cmd;
      item.key = key;
      gap = gap_len();
      if (gap > 0) begin
         start       <= 1'b0;
         req_payload <= req_type'({1'($urandom), $urandom});
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(start && !busy));
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic lookup(input logic [31:0] key);
      drive_item(CMD_LOOKUP, key);
   endtask

   task automatic insert(input logic [31:0] key);
      drive_item(CMD_INSERT, key);
      recent_keys.push_back(key);
      if (recent_keys.size() > 16) void'(recent_keys.pop_front());
   endtask

   // --------------------------------------------------------------------------
   // Response monitor
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_payload);
   end

   // --------------------------------------------------------------------------
   // Watchdog: cycles without any transfer on either side
   // --------------------------------------------------------------------------
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      logic [31:0] key;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      items_sent  = 0;
      burst_left  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill every slot first so no lookup compares against an unwritten tag
      insert(32'h0000_0000);
      insert(32'hFFFF_FFFF);
      insert(32'hA5A5_A5A5);
      insert(32'h5A5A_5A5A);
      for (int k = 1; k <= 6; k++) insert(32'(k));
      // touch slots 0..8; slot 9 is already marked used by its insert
      lookup(32'h0000_0000);
      lookup(32'hFFFF_FFFF);
      lookup(32'hA5A5_A5A5);
      lookup(32'h5A5A_5A5A);
      for (int k = 1; k <= 5; k++) lookup(32'(k));
      // all use bits set: full turn, lands back on the start slot
      insert(32'h8000_0000);
      // duplicate tag overwrites slot 0; lower copy must win afterwards
      insert(32'hFFFF_FFFF);
      lookup(32'hFFFF_FFFF);
      lookup(32'h0000_0000);
      lookup(32'h1234_5678);

      // random traffic, mostly miss-then-insert and hits on recent tags
      while (items_sent < RANDOM_ITEMS + 24) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            lookup(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
         end else if (pick < 65) begin
            key = $urandom;
            lookup(key);
            insert(key);
         end else if (pick < 75) begin
            insert(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
         end else if (pick < 85) begin
            lookup($urandom);
         end else begin
            // narrow tag space for repeated and colliding tags
            key = $urandom_range(0, 7);
            if ($urandom_range(0, 1)) insert(key);
            else lookup(key);
         end
      end
      start <= 1'b0;

      // drain, then let the datapath settle
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (ENTRIES + 4) @(posedge clock);

      $display("Ran %0d lookups (%0d hits) and %0d inserts, %0d of them full-turn sweeps.",
               sb.lookups, sb.hits, sb.inserts, sb.full_turns);
      $display("Compared %0d responses, %0d field errors.", sb.checked, sb.failures);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
